// File: rtl/obinf_pkg.sv
package obinf_pkg;

  localparam int POS_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int DIM_W      = 9;
  localparam int RAD_W      = 4;
  localparam int CODE_W     = 2;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CODE_W-1:0] CODE_WHITE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_GRAY  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_BLACK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 3'd5;

  localparam logic [DIM_W-1:0]  RST_MAP_WIDTH   = 9'd256;
  localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT  = 9'd256;
  localparam logic [RAD_W-1:0]  RST_RADIUS      = 4'd4;
  localparam logic [CHAN_W-1:0] RST_BLACK_LEVEL = 8'd0;
  localparam logic [CHAN_W-1:0] RST_GRAY_LEVEL  = 8'd128;
  localparam logic [CHAN_W-1:0] RST_WHITE_LEVEL = 8'd255;

  typedef struct packed {
    logic capture;
    logic clr_init;
    logic setup;
    logic mask;
    logic rd_row;
    logic wr_row;
    logic clr_row;
    logic row_step;
    logic rd_item;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic act_load_go;
    logic act_read;
    logic act_clear;
    logic read_store;
    logic row_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/obinf_ram.sv
module obinf_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH))
  (input  logic              clk,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/obinf_ctrl.sv
module obinf_ctrl import obinf_pkg::*;
  (input  logic  clk,
   input  logic  rst,
   input  logic  in_valid,
   output logic  in_ready,
   input  stat_t stat,
   output cmd_t  cmd);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_MASK,
    S_RD,
    S_WR,
    S_RD_ITEM,
    S_RESULT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_row = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.row_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.act_clear) begin
            cmd.clr_init = 1'b1;
            state_next   = S_CLEAR;
          end else if (stat.act_load_go) begin
            state_next = S_SETUP;
          end else if (stat.act_read) begin
            state_next = stat.read_store ? S_RD_ITEM : S_RESULT;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MASK;
      end
      S_MASK: begin
        cmd.mask   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_row = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_row = 1'b1;
        if (stat.row_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.row_step = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD_ITEM: begin
        cmd.rd_item = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register can take the transaction
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/obinf_datapath.sv
module obinf_datapath import obinf_pkg::*;
  #(parameter int MAX_MAP_WIDTH = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int MAX_RADIUS = 8)
  (input  logic                  clk,
   input  logic                  rst,
   input  cmd_t                  cmd,
   output stat_t                 stat,
   input  logic [ACT_W-1:0]      action,
   input  logic [POS_W-1:0]      pos_x,
   input  logic [POS_W-1:0]      pos_y,
   input  logic [CHAN_W-1:0]     red,
   input  logic [CHAN_W-1:0]     green,
   input  logic [CHAN_W-1:0]     blue,
   input  logic                  cfg_write,
   input  logic [CFG_IDX_W-1:0]  cfg_index,
   input  logic [CFG_DATA_W-1:0] cfg_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CODE_W-1:0]     level_code,
   output logic [CHAN_W-1:0]     level_byte,
   output logic                  in_range);

  localparam int STRIDE = MAX_MAP_WIDTH + 2 * MAX_RADIUS;
  localparam int ROWS   = MAX_MAP_HEIGHT + 2 * MAX_RADIUS;
  localparam int AW     = $clog2(ROWS);
  localparam int XIW    = $clog2(STRIDE);
  localparam int CW     = $clog2(MAX_MAP_WIDTH + MAX_MAP_HEIGHT + 8 * MAX_RADIUS + 1024);
  localparam int ROW_W  = CODE_W * STRIDE;

  // configuration registers
  logic [DIM_W-1:0]  map_width, map_height;
  logic [RAD_W-1:0]  inflation_radius;
  logic [CHAN_W-1:0] black_level, gray_level, white_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width        <= RST_MAP_WIDTH;
      map_height       <= RST_MAP_HEIGHT;
      inflation_radius <= RST_RADIUS;
      black_level      <= RST_BLACK_LEVEL;
      gray_level       <= RST_GRAY_LEVEL;
      white_level      <= RST_WHITE_LEVEL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_WIDTH:   map_width        <= cfg_data;
        REG_MAP_HEIGHT:  map_height       <= cfg_data;
        REG_RADIUS:      inflation_radius <= cfg_data[RAD_W-1:0];
        REG_BLACK_LEVEL: black_level      <= cfg_data[CHAN_W-1:0];
        REG_GRAY_LEVEL:  gray_level       <= cfg_data[CHAN_W-1:0];
        REG_WHITE_LEVEL: white_level      <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions, saturated to the store size
  logic [CW-1:0] cw_raw, ch_raw, cr_raw;
  logic [CW-1:0] eff_w, eff_h, eff_r, wi, hi;

  always_comb begin
    cw_raw = CW'(map_width);
    ch_raw = CW'(map_height);
    cr_raw = CW'(inflation_radius);
    eff_w  = (cw_raw > CW'(MAX_MAP_WIDTH))  ? CW'(MAX_MAP_WIDTH)  : cw_raw;
    eff_h  = (ch_raw > CW'(MAX_MAP_HEIGHT)) ? CW'(MAX_MAP_HEIGHT) : ch_raw;
    eff_r  = (cr_raw > CW'(MAX_RADIUS))     ? CW'(MAX_RADIUS)     : cr_raw;
    wi     = eff_w + eff_r + eff_r;
    hi     = eff_h + eff_r + eff_r;
  end

  // decode of the offered item
  logic [CW-1:0] in_x, in_y;
  logic          obstacle, inside_map, inside_infl, inside_core;

  always_comb begin
    in_x        = CW'(pos_x);
    in_y        = CW'(pos_y);
    obstacle    = (red == black_level) || (green == black_level) || (blue == black_level);
    inside_map  = (in_x < eff_w) && (in_y < eff_h);
    inside_infl = (in_x < wi) && (in_y < hi);
    inside_core = (in_x >= eff_r) && (in_x < eff_w + eff_r) &&
                  (in_y >= eff_r) && (in_y < eff_h + eff_r);
  end

  // captured item
  logic [CW-1:0] px, py;
  logic          rd_inr, rd_store;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px       <= in_x;
      py       <= in_y;
      rd_inr   <= inside_infl;
      rd_store <= inside_infl && inside_core;
    end
  end

  // box bounds
  logic [CW-1:0] gx0, gx1, gy_last, bx1, by1;
  logic [CW-1:0] r2, r3, gx1_raw, gy1_raw, gy0;

  always_comb begin
    r2      = eff_r + eff_r;
    r3      = r2 + eff_r;
    gx1_raw = px + r3;
    gy1_raw = py + r3;
    gy0     = (py > eff_r) ? py - eff_r : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      gx0     <= (px > eff_r) ? px - eff_r : '0;
      gx1     <= (gx1_raw > wi) ? wi : gx1_raw;
      gy_last <= ((gy1_raw > hi) ? hi : gy1_raw) - CW'(1);
      bx1     <= px + r2;
      by1     <= py + r2;
    end
  end

  // column masks of the gray and black boxes
  logic [STRIDE-1:0] gmask, bmask;

  always_ff @(posedge clk) begin
    if (cmd.mask) begin
      for (int i = 0; i < STRIDE; i++) begin
        gmask[i] <= (CW'(i) >= gx0) && (CW'(i) < gx1);
        bmask[i] <= (CW'(i) >= px) && (CW'(i) < bx1);
      end
    end
  end

  // row counter, shared by the paint loop and the clearing sweep
  logic [AW-1:0] row;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      row <= '0;
    end else if (cmd.setup) begin
      row <= gy0[AW-1:0];
    end else if (cmd.row_step) begin
      row <= row + AW'(1);
    end
  end

  // row store
  logic [ROW_W-1:0]  rd_data, wr_data, new_row;
  logic [AW-1:0]     raddr;
  logic [CODE_W-1:0] cells [STRIDE];
  logic              black_row;

  always_comb begin
    black_row = (CW'(row) >= py) && (CW'(row) < by1);
    for (int i = 0; i < STRIDE; i++) begin
      cells[i] = rd_data[CODE_W*i +: CODE_W];
      if (black_row && bmask[i]) begin
        new_row[CODE_W*i +: CODE_W] = CODE_BLACK;
      end else if (gmask[i] && (cells[i] == CODE_WHITE)) begin
        new_row[CODE_W*i +: CODE_W] = CODE_GRAY;
      end else begin
        new_row[CODE_W*i +: CODE_W] = cells[i];
      end
    end
  end

  assign wr_data = cmd.clr_row ? '0 : new_row;
  assign raddr   = cmd.rd_item ? py[AW-1:0] : row;

  obinf_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_store (
    .clk   (clk),
    .we    (cmd.wr_row | cmd.clr_row),
    .waddr (row),
    .wdata (wr_data),
    .re    (cmd.rd_row | cmd.rd_item),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // result register
  logic [CODE_W-1:0] entry, code;

  always_comb begin
    entry = cells[px[XIW-1:0]];
    if (!rd_store || entry == CODE_BLACK || entry > CODE_BLACK) begin
      code = CODE_BLACK;
    end else begin
      code = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      level_code <= code;
      in_range   <= rd_inr;
      case (code)
        CODE_BLACK: level_byte <= black_level;
        CODE_GRAY:  level_byte <= gray_level;
        default:    level_byte <= white_level;
      endcase
    end
  end

  always_comb begin
    stat.act_load_go = (action == ACT_LOAD) && inside_map && obstacle && (eff_r != '0);
    stat.act_read    = (action == ACT_READ);
    stat.act_clear   = (action == ACT_CLEAR);
    stat.read_store  = inside_infl && inside_core;
    stat.row_last    = (CW'(row) == gy_last);
    stat.clr_last    = (row == AW'(ROWS - 1));
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

// File: rtl/two_level_obstacle_inflation_top.sv
// Two-level obstacle inflation. The inflated map (input map padded by r on every
// side) lives in a row-wide RAM, one row of 2-bit codes per address. A load of
// an obstacle pixel sets up its box bounds and column masks, then walks the n
// rows of its clipped gray box (n at most 4r): every row is read, darkened and
// written back through the RAM's single read and single write port. Loads of
// free pixels, pixels outside the map, unused action codes and any load with
// r = 0 leave the store untouched. A read of a core pixel reads its row from the
// RAM, frame or out-of-range pixels skip that read, and both may wait for the
// output register. A clear item and the clearing pass after reset sweep all
// MAX_MAP_HEIGHT + 2*MAX_RADIUS rows, one per cycle, with in_ready low;
// configuration writes are taken at any time but must only be issued while idle.
module two_level_obstacle_inflation_top import obinf_pkg::*;
  #(parameter int MAX_MAP_WIDTH = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int MAX_RADIUS = 8)
  (input  logic                  clk,
   input  logic                  rst,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ACT_W-1:0]      action,
   input  logic [POS_W-1:0]      pos_x,
   input  logic [POS_W-1:0]      pos_y,
   input  logic [CHAN_W-1:0]     red,
   input  logic [CHAN_W-1:0]     green,
   input  logic [CHAN_W-1:0]     blue,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CODE_W-1:0]     level_code,
   output logic [CHAN_W-1:0]     level_byte,
   output logic                  in_range,
   input  logic                  cfg_write,
   input  logic [CFG_IDX_W-1:0]  cfg_index,
   input  logic [CFG_DATA_W-1:0] cfg_data);

  cmd_t  cmd;
  stat_t stat;

  obinf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  obinf_datapath #(
    .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
    .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
    .MAX_RADIUS     (MAX_RADIUS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (action),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .level_code (level_code),
    .level_byte (level_byte),
    .in_range   (in_range)
  );

endmodule
